// File: design/bba_pkg.sv
// Package: shared types and constants for the bounding box accumulator.
package bba_pkg;

  localparam int unsigned AXES = 3;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned EXT_W = COORD_W + 1;
  localparam int unsigned PAIR_W = 2 * EXT_W;
  localparam int unsigned AREA_W = 36;
  localparam int unsigned VOL_W = 49;

  localparam logic [2:0] FUNC_CLEAR = 3'd0;
  localparam logic [2:0] FUNC_ADD_POINT = 3'd1;
  localparam logic [2:0] FUNC_ADD_BOX = 3'd2;
  localparam logic [2:0] FUNC_SET_BOX = 3'd3;
  localparam logic [2:0] FUNC_CONTAINS = 3'd4;
  localparam logic [2:0] FUNC_STRICT = 3'd5;
  localparam logic [2:0] FUNC_INTERSECTS = 3'd6;

  localparam logic signed [COORD_W-1:0] MIN_RESET = 16'sh7fff;
  localparam logic signed [COORD_W-1:0] MAX_RESET = -16'sh8000;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD,
    S_EXT,
    S_MXY,
    S_MYZ,
    S_MXZ,
    S_VOL,
    S_LOAD
  } state_t;

  typedef enum logic [1:0] {
    MUL_XY,
    MUL_YZ,
    MUL_XZ,
    MUL_VOL
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     update;
    logic     extent;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     load;
  } cmd_t;

endpackage

// File: design/bba_if.sv
// Interfaces: input and result channels of the bounding box accumulator.
interface bba_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic signed [15:0] ax;
  logic signed [15:0] ay;
  logic signed [15:0] az;
  logic signed [15:0] bx;
  logic signed [15:0] by;
  logic signed [15:0] bz;

  modport source (output valid, func, ax, ay, az, bx, by, bz, input ready);
  modport sink (input valid, func, ax, ay, az, bx, by, bz, output ready);
endinterface

interface bba_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] low_x;
  logic signed [15:0] low_y;
  logic signed [15:0] low_z;
  logic signed [15:0] high_x;
  logic signed [15:0] high_y;
  logic signed [15:0] high_z;
  logic               empty_res;
  logic               valid_res;
  logic               hit;
  logic signed [35:0] area;
  logic signed [48:0] volume;

  modport source (output valid, low_x, low_y, low_z, high_x, high_y, high_z,
                  empty_res, valid_res, hit, area, volume, input ready);
  modport sink (input valid, low_x, low_y, low_z, high_x, high_y, high_z,
                empty_res, valid_res, hit, area, volume, output ready);
endinterface

// File: design/bba_ctrl.sv
// Controller: sequences update, extents, shared multiplier and result load.
module bba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output bba_pkg::cmd_t    cmd
);

  bba_pkg::state_t state;
  bba_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      bba_pkg::S_IDLE: if (in_valid) state_next = bba_pkg::S_UPD;
      bba_pkg::S_UPD:  state_next = bba_pkg::S_EXT;
      bba_pkg::S_EXT:  state_next = bba_pkg::S_MXY;
      bba_pkg::S_MXY:  state_next = bba_pkg::S_MYZ;
      bba_pkg::S_MYZ:  state_next = bba_pkg::S_MXZ;
      bba_pkg::S_MXZ:  state_next = bba_pkg::S_VOL;
      bba_pkg::S_VOL:  state_next = bba_pkg::S_LOAD;
      bba_pkg::S_LOAD: if (out_free) state_next = bba_pkg::S_IDLE;
      default:         state_next = bba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    cmd.extent  = 1'b0;
    cmd.mul_en  = 1'b0;
    cmd.mul_sel = bba_pkg::MUL_XY;
    cmd.load    = 1'b0;
    case (state)
      bba_pkg::S_IDLE: begin
        in_ready    = !rst;
        cmd.capture = in_valid && !rst;
      end
      bba_pkg::S_UPD: cmd.update = 1'b1;
      bba_pkg::S_EXT: cmd.extent = 1'b1;
      bba_pkg::S_MXY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bba_pkg::MUL_XY;
      end
      bba_pkg::S_MYZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bba_pkg::MUL_YZ;
      end
      bba_pkg::S_MXZ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bba_pkg::MUL_XZ;
      end
      bba_pkg::S_VOL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = bba_pkg::MUL_VOL;
      end
      bba_pkg::S_LOAD: cmd.load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bba_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == bba_pkg::S_UPD)
    else $error("accepted transaction did not start update");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("result load did not raise output valid");

  a_load_waits: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::S_LOAD && out_valid && !out_ready) |=> state == bba_pkg::S_LOAD)
    else $error("result load overran a waiting result");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == bba_pkg::S_UPD) |-> !in_ready && !cmd.load)
    else $error("input taken while an item is in progress");
`endif

endmodule

// File: design/bba_dp.sv
// Datapath: box state, operand capture, tests, extents, multiplier, result register.
module bba_dp (
  input  logic               clk,
  input  logic               rst,
  input  bba_pkg::cmd_t      cmd,
  input  logic [2:0]         func,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] az,
  input  logic signed [15:0] bx,
  input  logic signed [15:0] by,
  input  logic signed [15:0] bz,
  output logic signed [15:0] low_x,
  output logic signed [15:0] low_y,
  output logic signed [15:0] low_z,
  output logic signed [15:0] high_x,
  output logic signed [15:0] high_y,
  output logic signed [15:0] high_z,
  output logic               empty_res,
  output logic               valid_res,
  output logic               hit,
  output logic signed [35:0] area,
  output logic signed [48:0] volume
);

  localparam int unsigned CW = bba_pkg::COORD_W;
  localparam int unsigned EW = bba_pkg::EXT_W;
  localparam int unsigned PW = bba_pkg::PAIR_W;
  localparam int unsigned AW = bba_pkg::AREA_W;
  localparam int unsigned VW = bba_pkg::VOL_W;
  localparam int unsigned MW = PW + EW;

  logic [2:0]              func_q;
  bba_pkg::coord_t         a_q [bba_pkg::AXES];
  bba_pkg::coord_t         b_q [bba_pkg::AXES];
  bba_pkg::coord_t         min_c [bba_pkg::AXES];
  bba_pkg::coord_t         max_c [bba_pkg::AXES];
  bba_pkg::coord_t         min_c_next [bba_pkg::AXES];
  bba_pkg::coord_t         max_c_next [bba_pkg::AXES];
  logic                    empty_q;
  logic                    empty_q_next;
  logic                    hit_next;
  logic                    hit_q;
  logic                    degen;
  logic                    ok_in;
  logic                    ok_strict;
  logic                    ok_ovl;
  bba_pkg::coord_t         base_min;
  bba_pkg::coord_t         base_max;
  logic signed [EW-1:0]    d [bba_pkg::AXES];
  logic                    differ;
  logic                    differ_next;
  logic signed [PW-1:0]    mul_a;
  logic signed [EW-1:0]    mul_b;
  logic signed [MW-1:0]    prod;
  logic signed [PW-1:0]    pxy;
  logic signed [PW-1:0]    pyz;
  logic signed [PW-1:0]    pxz;
  logic signed [VW-1:0]    vol_q;
  logic signed [AW:0]      sum;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= func;
      a_q[0] <= ax;
      a_q[1] <= ay;
      a_q[2] <= az;
      b_q[0] <= bx;
      b_q[1] <= by;
      b_q[2] <= bz;
    end
  end

  always_comb begin
    degen       = 1'b1;
    differ_next = 1'b0;
    ok_in       = !empty_q;
    ok_strict   = !empty_q;
    ok_ovl      = !empty_q;
    for (int i = 0; i < bba_pkg::AXES; i++) begin
      if (a_q[i] != b_q[i]) degen = 1'b0;
      if (max_c[i] != min_c[i]) differ_next = 1'b1;
      if (!(min_c[i] <= a_q[i] && a_q[i] <= max_c[i])) ok_in = 1'b0;
      if (!(min_c[i] < a_q[i] && a_q[i] < max_c[i])) ok_strict = 1'b0;
      if (!(min_c[i] <= b_q[i] && max_c[i] >= a_q[i])) ok_ovl = 1'b0;
    end
  end

  always_comb begin
    empty_q_next = empty_q;
    hit_next     = 1'b0;
    base_min     = '0;
    base_max     = '0;
    for (int i = 0; i < bba_pkg::AXES; i++) begin
      min_c_next[i] = min_c[i];
      max_c_next[i] = max_c[i];
    end
    case (func_q)
      bba_pkg::FUNC_CLEAR: begin
        empty_q_next = 1'b1;
        for (int i = 0; i < bba_pkg::AXES; i++) begin
          min_c_next[i] = bba_pkg::MIN_RESET;
          max_c_next[i] = bba_pkg::MAX_RESET;
        end
      end
      bba_pkg::FUNC_ADD_POINT: begin
        empty_q_next = 1'b0;
        for (int i = 0; i < bba_pkg::AXES; i++) begin
          if (empty_q || a_q[i] < min_c[i]) min_c_next[i] = a_q[i];
          if (empty_q || a_q[i] > max_c[i]) max_c_next[i] = a_q[i];
        end
      end
      bba_pkg::FUNC_ADD_BOX: begin
        if (!degen) begin
          empty_q_next = 1'b0;
          for (int i = 0; i < bba_pkg::AXES; i++) begin
            base_min = (empty_q || a_q[i] < min_c[i]) ? a_q[i] : min_c[i];
            base_max = (empty_q || a_q[i] > max_c[i]) ? a_q[i] : max_c[i];
            min_c_next[i] = (b_q[i] < base_min) ? b_q[i] : base_min;
            max_c_next[i] = (b_q[i] > base_max) ? b_q[i] : base_max;
          end
        end
      end
      bba_pkg::FUNC_SET_BOX: begin
        empty_q_next = 1'b0;
        for (int i = 0; i < bba_pkg::AXES; i++) begin
          min_c_next[i] = a_q[i];
          max_c_next[i] = b_q[i];
        end
      end
      bba_pkg::FUNC_CONTAINS:   hit_next = ok_in;
      bba_pkg::FUNC_STRICT:     hit_next = ok_strict;
      bba_pkg::FUNC_INTERSECTS: hit_next = ok_ovl;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_q <= 1'b1;
      for (int i = 0; i < bba_pkg::AXES; i++) begin
        min_c[i] <= bba_pkg::MIN_RESET;
        max_c[i] <= bba_pkg::MAX_RESET;
      end
    end else if (cmd.update) begin
      empty_q <= empty_q_next;
      for (int i = 0; i < bba_pkg::AXES; i++) begin
        min_c[i] <= min_c_next[i];
        max_c[i] <= max_c_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hit_q <= hit_next;
    end
    if (cmd.extent) begin
      differ <= differ_next;
      for (int i = 0; i < bba_pkg::AXES; i++) begin
        d[i] <= {max_c[i][CW-1], max_c[i]} - {min_c[i][CW-1], min_c[i]};
      end
    end
  end

  // shared multiplier: three extent pairs, then (dx*dy)*dz
  always_comb begin
    mul_a = {{(PW-EW){d[0][EW-1]}}, d[0]};
    mul_b = d[1];
    case (cmd.mul_sel)
      bba_pkg::MUL_XY: begin
        mul_a = {{(PW-EW){d[0][EW-1]}}, d[0]};
        mul_b = d[1];
      end
      bba_pkg::MUL_YZ: begin
        mul_a = {{(PW-EW){d[2][EW-1]}}, d[2]};
        mul_b = d[1];
      end
      bba_pkg::MUL_XZ: begin
        mul_a = {{(PW-EW){d[0][EW-1]}}, d[0]};
        mul_b = d[2];
      end
      bba_pkg::MUL_VOL: begin
        mul_a = pxy;
        mul_b = d[2];
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        bba_pkg::MUL_XY:  pxy <= prod[PW-1:0];
        bba_pkg::MUL_YZ:  pyz <= prod[PW-1:0];
        bba_pkg::MUL_XZ:  pxz <= prod[PW-1:0];
        bba_pkg::MUL_VOL: vol_q <= prod[VW-1:0];
        default: ;
      endcase
    end
  end

  assign sum = {{(AW+1-PW){pxy[PW-1]}}, pxy} + {{(AW+1-PW){pyz[PW-1]}}, pyz}
             + {{(AW+1-PW){pxz[PW-1]}}, pxz};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      low_x     <= min_c[0];
      low_y     <= min_c[1];
      low_z     <= min_c[2];
      high_x    <= max_c[0];
      high_y    <= max_c[1];
      high_z    <= max_c[2];
      empty_res <= empty_q;
      valid_res <= !empty_q && differ;
      hit       <= hit_q;
      area      <= empty_q ? '0 : {sum[AW-2:0], 1'b0};
      volume    <= empty_q ? '0 : vol_q;
    end
  end

endmodule

// File: design/bounding_box_accumulator_top.sv
// Top level: 3D axis-aligned bounding box accumulator, Q8.8 corners.
//
//  channel  | dir | payload
//  in_ch    | in  | func, ax, ay, az, bx, by, bz
//  out_ch   | out | low/high corners, empty_res, valid_res, hit, area, volume
//
// Each transaction steps through capture, update, extents, four passes through
// one shared 34x17 multiplier and result load.
// The next transaction is taken while a result waits in the output register.
// A result not taken stalls the load cycle, and with it the next transaction.
// Synchronous reset returns the box to empty with sentinel corners.
module bounding_box_accumulator_top (
  input  logic       clk,
  input  logic       rst,
  bba_in_if.sink     in_ch,
  bba_out_if.source  out_ch
);

  bba_pkg::cmd_t cmd;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  bba_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .func      (in_ch.func),
    .ax        (in_ch.ax),
    .ay        (in_ch.ay),
    .az        (in_ch.az),
    .bx        (in_ch.bx),
    .by        (in_ch.by),
    .bz        (in_ch.bz),
    .low_x     (out_ch.low_x),
    .low_y     (out_ch.low_y),
    .low_z     (out_ch.low_z),
    .high_x    (out_ch.high_x),
    .high_y    (out_ch.high_y),
    .high_z    (out_ch.high_z),
    .empty_res (out_ch.empty_res),
    .valid_res (out_ch.valid_res),
    .hit       (out_ch.hit),
    .area      (out_ch.area),
    .volume    (out_ch.volume)
  );

endmodule
